// ----- sv/sndd_pkg.sv -----
`timescale 1ns / 1ps
// shared constants, types and helpers of the silence and no-dynamic detector
// no dependencies; imported by every module of the block

package sndd_pkg;

    // sample and counter sizing
    localparam int SAMPLE_BITS = 24;
    localparam int COUNT_BITS  = 16;

    // fixed field widths
    localparam int STATUS_W     = 3;
    localparam int TICK_W       = 16;
    localparam int LEVEL_W      = 11;
    localparam int SIL_LVL_W    = 10;
    localparam int FLAT_DELTA_W = 10;
    localparam int PERIOD_W     = 16;
    localparam int GRACE_W      = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 3;

    // stream packing
    localparam int IN_DATA_W   = ((SAMPLE_BITS + 1 + 7) / 8) * 8;
    localparam int OUT_FIELD_W = TICK_W + LEVEL_W + 2;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;

    // level conversion
    localparam int LOG_FRAC    = 16;
    localparam int LOG_E_W     = $clog2(SAMPLE_BITS);
    localparam int LOG_W       = LOG_E_W + LOG_FRAC;
    localparam int MANT_W      = 32;
    localparam int SHIFT_W     = 5;
    localparam int DB_OCT_W    = 21;
    localparam int N_W         = LOG_W + DB_OCT_W;
    localparam int MAG_W       = N_W - 31;
    localparam int LEVEL_FLOOR = 600;
    localparam int CONV_LAT    = LOG_FRAC + 3;
    localparam int WAIT_W      = $clog2(CONV_LAT + 1);

    localparam logic [DB_OCT_W-1:0] DB_OCT_Q16 = DB_OCT_W'(1578264);
    localparam logic [LOG_W-1:0] LOG_FULL = LOG_W'(SAMPLE_BITS - 1) << LOG_FRAC;
    localparam logic [N_W:0] ROUND_BIAS = (N_W + 1)'(33'h0_7FFF_FFFF);
    localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = LEVEL_W'(-LEVEL_FLOOR);

    typedef enum logic [STATUS_W-1:0] {
        ST_GRACE    = 3'd0,
        ST_UNCONN   = 3'd1,
        ST_NEW_CONN = 3'd2,
        ST_BELOW    = 3'd3,
        ST_ABOVE    = 3'd4,
        ST_SILENCE  = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SILENCE_LEVEL = 3'd0,
        CFG_SILENCE_TICKS = 3'd1,
        CFG_FLAT_DELTA    = 3'd2,
        CFG_FLAT_TICKS    = 3'd3,
        CFG_GRACE_TICKS   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SIL_LVL_W-1:0] silence_level;
        logic [PERIOD_W-1:0]         silence_ticks;
        logic [FLAT_DELTA_W-1:0]     flat_delta_level;
        logic [PERIOD_W-1:0]         flat_ticks;
        logic [GRACE_W-1:0]          grace_ticks;
    } t_cfg;

    typedef struct packed {
        logic [GRACE_W-1:0]        grace_left;
        logic                      announce;
        logic [COUNT_BITS-1:0]     silent_run;
        logic [COUNT_BITS-1:0]     loud_run;
        logic [COUNT_BITS-1:0]     flat_run;
        logic signed [LEVEL_W-1:0] level_now;
    } t_state;

    typedef struct packed {
        t_status                   status;
        logic [TICK_W-1:0]         tick_count;
        logic signed [LEVEL_W-1:0] peak_level;
        logic                      silence_hit;
        logic                      flat_hit;
    } t_result;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

endpackage

// ----- sv/sndd_level_conv.sv -----
`timescale 1ns / 1ps
// peak magnitude to quarter-dB level, free-running pipeline of CONV_LAT stages
// depends on sndd_pkg

module sndd_level_conv (
    input  logic                                  i_clk,
    input  logic [sndd_pkg::SAMPLE_BITS-1:0]      i_peak,
    output logic signed [sndd_pkg::LEVEL_W-1:0]   o_level
);
    import sndd_pkg::*;

    logic [LOG_E_W-1:0]   w_e;
    logic [MANT_W-1:0]    w_norm;

    logic [MANT_W-1:0]    r_m    [0:LOG_FRAC];
    logic [LOG_E_W-1:0]   r_e    [0:LOG_FRAC];
    logic [LOG_FRAC-1:0]  r_frac [0:LOG_FRAC];

    logic [2*MANT_W-1:0]  w_sq   [0:LOG_FRAC-1];
    logic [MANT_W:0]      w_sqt  [0:LOG_FRAC-1];

    logic [LOG_W-1:0]     w_lg;
    logic [LOG_W-1:0]     w_d;
    logic [N_W-1:0]       r_n;
    logic [N_W:0]         w_rnd;
    logic [MAG_W-1:0]     w_mag;
    logic [MAG_W-1:0]     w_cap;

    // msb index of the peak
    always_comb begin
        w_e = '0;
        for (int b = 0; b < SAMPLE_BITS; b++) begin
            if (i_peak[b]) begin
                w_e = LOG_E_W'(b);
            end
        end
    end

    // mantissa in q31, msb at bit 31
    assign w_norm = MANT_W'(i_peak) << (SHIFT_W'(MANT_W - 1) - SHIFT_W'(w_e));

    // one fraction bit per stage: square, renormalize when >= 2.0
    for (genvar k = 0; k < LOG_FRAC; k++) begin : g_sq
        assign w_sq[k]  = {{MANT_W{1'b0}}, r_m[k]} * {{MANT_W{1'b0}}, r_m[k]};
        assign w_sqt[k] = w_sq[k][2*MANT_W-1:MANT_W-1];
    end

    always_ff @(posedge i_clk) begin
        r_m[0]    <= w_norm;
        r_e[0]    <= w_e;
        r_frac[0] <= '0;
        for (int k = 0; k < LOG_FRAC; k++) begin
            r_m[k+1]    <= w_sqt[k][MANT_W] ? w_sqt[k][MANT_W:1] : w_sqt[k][MANT_W-1:0];
            r_e[k+1]    <= r_e[k];
            r_frac[k+1] <= r_frac[k]
                         | (LOG_FRAC'(w_sqt[k][MANT_W]) << (LOG_FRAC - 1 - k));
        end
    end

    // distance below full scale in octaves, scaled to quarter dB in q32
    assign w_lg = {r_e[LOG_FRAC], r_frac[LOG_FRAC]};
    assign w_d  = (w_lg > LOG_FULL) ? '0 : LOG_FULL - w_lg;

    always_ff @(posedge i_clk) begin
        r_n <= N_W'(w_d) * N_W'(DB_OCT_Q16);
    end

    // round to nearest, tie toward zero, floor at -150 dB
    assign w_rnd = {1'b0, r_n} + ROUND_BIAS;
    assign w_mag = w_rnd[N_W:32];
    assign w_cap = (w_mag > MAG_W'(LEVEL_FLOOR)) ? MAG_W'(LEVEL_FLOOR) : w_mag;

    always_ff @(posedge i_clk) begin
        o_level <= LEVEL_W'(0) - LEVEL_W'(w_cap);
    end

endmodule

// ----- sv/sndd_tick_eval.sv -----
`timescale 1ns / 1ps
// per-tick decision: grace, unconnected, or measure and run the enabled tests
// depends on sndd_pkg

module sndd_tick_eval (
    input  sndd_pkg::t_cfg                       i_cfg,
    input  sndd_pkg::t_state                     i_state,
    input  logic                                 i_connected,
    input  logic signed [sndd_pkg::LEVEL_W-1:0]  i_level,
    output sndd_pkg::t_state                     o_next_state,
    output sndd_pkg::t_result                    o_result,
    output logic                                 o_measure
);
    import sndd_pkg::*;

    logic                     w_below;
    logic [COUNT_BITS-1:0]    w_sil_new;
    logic [COUNT_BITS-1:0]    w_loud_new;
    logic                     w_sil_fire;
    logic signed [LEVEL_W:0]  w_diff;
    logic [LEVEL_W:0]         w_delta;
    logic [COUNT_BITS-1:0]    w_flat_new;
    logic                     w_flat_fire;

    assign w_below    = i_level < $signed(LEVEL_W'(i_cfg.silence_level));
    assign w_sil_new  = w_below ? sat_inc(i_state.silent_run) : '0;
    assign w_loud_new = w_below ? '0 : sat_inc(i_state.loud_run);
    assign w_sil_fire = 32'(w_sil_new) >= 32'(i_cfg.silence_ticks);

    assign w_diff  = {i_state.level_now[LEVEL_W-1], i_state.level_now}
                   - {i_level[LEVEL_W-1], i_level};
    assign w_delta = w_diff[LEVEL_W] ? (LEVEL_W + 1)'(-w_diff) : (LEVEL_W + 1)'(w_diff);
    assign w_flat_new  = (w_delta < (LEVEL_W + 1)'(i_cfg.flat_delta_level))
                       ? sat_inc(i_state.flat_run) : '0;
    assign w_flat_fire = 32'(w_flat_new) >= 32'(i_cfg.flat_ticks);

    always_comb begin
        o_next_state = i_state;
        o_result     = '0;
        o_measure    = 1'b0;
        if (i_state.grace_left != '0) begin
            o_next_state.grace_left = i_state.grace_left - 1'b1;
            o_result.status         = ST_GRACE;
            o_result.tick_count     = TICK_W'(i_state.grace_left - 1'b1);
        end else if (!i_connected) begin
            o_next_state.announce = 1'b1;
            o_result.status       = ST_UNCONN;
        end else begin
            o_measure              = 1'b1;
            o_next_state.announce  = 1'b0;
            o_next_state.level_now = i_level;
            o_result.peak_level    = i_level;
            o_result.status        = i_state.announce ? ST_NEW_CONN : ST_ABOVE;

            if (i_cfg.silence_level != '0) begin
                o_next_state.silent_run = w_sil_new;
                o_next_state.loud_run   = w_loud_new;
                o_result.status         = w_below ? ST_BELOW : ST_ABOVE;
                o_result.tick_count     = w_below ? TICK_W'(w_sil_new) : TICK_W'(w_loud_new);
                if (w_sil_fire) begin
                    o_result.status         = ST_SILENCE;
                    o_result.tick_count     = TICK_W'(w_sil_new);
                    o_result.silence_hit    = 1'b1;
                    o_next_state.silent_run = '0;
                    o_next_state.grace_left = i_cfg.grace_ticks;
                end
            end

            if (i_cfg.flat_delta_level != '0) begin
                o_next_state.flat_run = w_flat_new;
                if (w_flat_fire) begin
                    o_result.flat_hit       = 1'b1;
                    o_next_state.flat_run   = '0;
                    o_next_state.grace_left = i_cfg.grace_ticks;
                end
            end
        end
    end

endmodule

// ----- sv/silence_and_no_dynamic_detector_core.sv -----
`timescale 1ns / 1ps
// top level of the silence and no-dynamic detector
// depends on sndd_pkg, sndd_level_conv, sndd_tick_eval
//
// usage
//   s_axis carries items: tuser[0] = 0 for an audio sample, 1 for a one-second
//   tick; tdata holds the sample and, on a tick, the connected flag.
//   m_axis carries one result per tick; samples give no result.
//   registers are written through i_cfg_we / i_cfg_index / i_cfg_data while idle.
// latency and throughput
//   samples are taken one per cycle, always. a tick result appears on m_axis
//   the cycle after the tick is accepted.
//   a tick that measures the level (no grace left, source connected) needs
//   the converted level of the current peak, so such a tick waits until the log2
//   pipeline has converted the last sample that raised the peak. with a zero
//   peak it goes at once. grace and unconnected ticks go one per cycle while
//   the result register has room.
// stalls
//   m_axis has one result register; while it is full and m_axis_tready is low
//   ticks are held off, samples keep flowing.
// reset
//   i_rst_n low clears the peak, run counters and grace, sets the connect
//   announcement, empties the result register and loads register defaults.

module silence_and_no_dynamic_detector_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [23:0] sample, [24] connected, rest zero
    input  logic [sndd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [0] action
    input  logic                                s_axis_tuser,

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [15:0] tick_count, [26:16] peak_level, [27] silence_hit, [28] flat_hit, rest zero
    output logic [sndd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // [2:0] status
    output logic [sndd_pkg::STATUS_W-1:0]       m_axis_tuser,

    input  logic                                i_cfg_we,
    input  logic [sndd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sndd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import sndd_pkg::*;

    t_cfg                       r_cfg;
    t_state                     r_state;
    t_state                     n_state;
    t_result                    w_res;
    t_result                    r_out;
    logic                       r_out_valid;
    logic [SAMPLE_BITS-1:0]     r_peak;
    logic [WAIT_W-1:0]          r_wait;

    logic                       w_is_tick;
    logic                       w_connected;
    logic [SAMPLE_BITS-1:0]     w_raw;
    logic [SAMPLE_BITS-1:0]     w_smag;
    logic signed [LEVEL_W-1:0]  w_conv_level;
    logic signed [LEVEL_W-1:0]  w_level;
    logic                       w_measure;
    logic                       w_level_ok;
    logic                       w_out_free;
    logic                       w_in_acc;
    logic                       w_tick_acc;

    assign w_is_tick   = s_axis_tuser;
    assign w_raw       = s_axis_tdata[SAMPLE_BITS-1:0];
    assign w_connected = s_axis_tdata[SAMPLE_BITS];
    assign w_smag      = w_raw[SAMPLE_BITS-1] ? (~w_raw + 1'b1) : w_raw;

    // level of the held peak, valid once the pipeline has caught up
    sndd_level_conv u_conv (
        .i_clk   (i_clk),
        .i_peak  (r_peak),
        .o_level (w_conv_level)
    );

    assign w_level    = (r_peak == '0) ? LEVEL_MIN : w_conv_level;
    assign w_level_ok = (r_wait == '0) || (r_peak == '0);

    sndd_tick_eval u_eval (
        .i_cfg        (r_cfg),
        .i_state      (r_state),
        .i_connected  (w_connected),
        .i_level      (w_level),
        .o_next_state (n_state),
        .o_result     (w_res),
        .o_measure    (w_measure)
    );

    // ticks need room in the result register and, if measuring, a settled level
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !w_is_tick || (w_out_free && (!w_measure || w_level_ok));
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_tick_acc    = w_in_acc && w_is_tick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.silence_level    <= SIL_LVL_W'(-160);
            r_cfg.silence_ticks    <= PERIOD_W'(1);
            r_cfg.flat_delta_level <= '0;
            r_cfg.flat_ticks       <= PERIOD_W'(10);
            r_cfg.grace_ticks      <= '0;
            r_state.grace_left     <= '0;
            r_state.announce       <= 1'b1;
            r_state.silent_run     <= '0;
            r_state.loud_run       <= '0;
            r_state.flat_run       <= '0;
            r_state.level_now      <= '0;
            r_peak                 <= '0;
            r_wait                 <= '0;
            r_out_valid            <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_SILENCE_LEVEL: r_cfg.silence_level    <= i_cfg_data[SIL_LVL_W-1:0];
                    CFG_SILENCE_TICKS: r_cfg.silence_ticks    <= i_cfg_data[PERIOD_W-1:0];
                    CFG_FLAT_DELTA:    r_cfg.flat_delta_level <= i_cfg_data[FLAT_DELTA_W-1:0];
                    CFG_FLAT_TICKS:    r_cfg.flat_ticks       <= i_cfg_data[PERIOD_W-1:0];
                    CFG_GRACE_TICKS:   r_cfg.grace_ticks      <= i_cfg_data[GRACE_W-1:0];
                    default: ;
                endcase
            end

            // peak hold; a rise restarts the conversion wait
            if (w_in_acc && !w_is_tick && (w_smag > r_peak)) begin
                r_peak <= w_smag;
                r_wait <= WAIT_W'(CONV_LAT);
            end else begin
                if (r_wait != '0) begin
                    r_wait <= r_wait - 1'b1;
                end
                if (w_tick_acc && w_measure) begin
                    r_peak <= '0;
                end
            end

            if (w_tick_acc) begin
                r_state <= n_state;
            end

            if (w_tick_acc) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_tick_acc) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out.flat_hit, r_out.silence_hit,
                            r_out.peak_level, r_out.tick_count};

    // a measuring tick empties the peak hold
    a_peak_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tick_acc && w_measure) |=> (r_peak == '0))
        else $error("peak not cleared after measuring tick");

    // a grace tick leaves the peak alone
    a_grace_keeps_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tick_acc && (r_state.grace_left != '0)) |=> $stable(r_peak))
        else $error("grace tick changed the peak");

    // any trigger loads the grace counter
    a_grace_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tick_acc && (w_res.silence_hit || w_res.flat_hit))
        |=> (r_state.grace_left == $past(r_cfg.grace_ticks)))
        else $error("grace not loaded on trigger");

    // a silence trigger is always reported with silence status
    a_hit_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.silence_hit) |-> (r_out.status == ST_SILENCE))
        else $error("silence hit without silence status");

endmodule
